// ===== sv/bpao_pkg.sv =====
// ----------------------------------------------------------------------------
// bpao_pkg
// Shared types, constants and the sine table of the back-EMF PLL observer.
// ----------------------------------------------------------------------------
package bpao_pkg;

	localparam int SineTableBits = 10;
	localparam int QBits = SineTableBits - 2;
	localparam int QSize = 1 << QBits;
	localparam int NumRegs = 6;
	localparam int AddrW = 5;

	typedef enum logic [2:0] {
		REG_RES  = 3'd0,
		REG_IND  = 3'd1,
		REG_KP   = 3'd2,
		REG_KI   = 3'd3,
		REG_DT   = 3'd4,
		REG_INV  = 3'd5
	} reg_idx_t;

	// datapath step commands
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLARKE,
		OP_EA_R,
		OP_EA_L1,
		OP_EA_L2,
		OP_EA_FIN,
		OP_EB_R,
		OP_EB_L1,
		OP_EB_L2,
		OP_EB_FIN,
		OP_EQ_C,
		OP_EQ_S,
		OP_EQ_FIN,
		OP_KI1,
		OP_KI2,
		OP_KP,
		OP_STEP1,
		OP_STEP2,
		OP_STEP3,
		OP_ANG,
		OP_ID_C,
		OP_ID_S,
		OP_IQ_C,
		OP_IQ_S,
		OP_DONE
	} op_t;

	typedef struct packed {
		logic [15:0] resistance;
		logic [15:0] inductance;
		logic [15:0] pll_kp;
		logic [15:0] pll_ki;
		logic [15:0] sample_period;
		logic [15:0] inv_sample_period;
	} cfg_t;

	typedef struct packed {
		op_t  op;
	} cmd_t;

	function automatic logic [15:0] quarter_sine(input logic [QBits:0] r);
		logic [33:0] xq, x2, t, y;
		logic [67:0] p;
		xq = 34'(r) << (18 - SineTableBits);
		p  = 68'(xq) * 68'(xq);
		x2 = 34'(p >> 16);
		p  = 68'(34'd4640) * 68'(x2);
		t  = 34'd42047 - 34'(p >> 16);
		p  = 68'(t) * 68'(x2);
		t  = 34'd102944 - 34'(p >> 16);
		p  = 68'(xq) * 68'(t);
		y  = (34'(p >> 16) + 34'd1) >> 1;
		if (y > 34'd32767) y = 34'd32767;
		return y[15:0];
	endfunction

	function automatic logic [QSize*16-1:0] build_sine_rom();
		logic [QSize*16-1:0] rom;
		rom = '0;
		for (int i = 0; i < QSize; i++) rom[i*16 +: 16] = quarter_sine((QBits+1)'(i));
		return rom;
	endfunction

	localparam logic [QSize*16-1:0] SineRom = build_sine_rom();
	localparam logic [15:0] SinePeak = quarter_sine((QBits+1)'(QSize));

	function automatic logic signed [16:0] sine_lut(input logic [15:0] ang);
		logic [SineTableBits-1:0] idx;
		logic [1:0]  quad;
		logic [QBits:0] r;
		logic [15:0] mag;
		idx  = ang[15 -: SineTableBits];
		quad = idx[SineTableBits-1 -: 2];
		r    = {1'b0, idx[QBits-1:0]};
		if (quad[0]) r = (QBits+1)'(1 << QBits) - r;
		mag  = r[QBits] ? SinePeak : SineRom[{r[QBits-1:0], 4'b0000} +: 16];
		return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

endpackage

// ===== sv/bpao_if.sv =====
// ----------------------------------------------------------------------------
// bpao_in_if / bpao_out_if
// Valid/ready channels of the observer.
// ----------------------------------------------------------------------------
interface bpao_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] phase_a_current;
	logic signed [15:0] phase_b_current;
	logic signed [15:0] v_alpha;
	logic signed [15:0] v_beta;
	modport source (output valid, phase_a_current, phase_b_current, v_alpha, v_beta,
		input ready);
	modport sink (input valid, phase_a_current, phase_b_current, v_alpha, v_beta,
		output ready);
endinterface

interface bpao_out_if;
	logic valid;
	logic ready;
	logic [15:0] angle;
	logic signed [31:0] speed;
	logic signed [15:0] i_d;
	logic signed [15:0] i_q;
	logic signed [15:0] emf_alpha;
	logic signed [15:0] emf_beta;
	modport source (output valid, angle, speed, i_d, i_q, emf_alpha, emf_beta,
		input ready);
	modport sink (input valid, angle, speed, i_d, i_q, emf_alpha, emf_beta,
		output ready);
endinterface

// ===== sv/bpao_regs.sv =====
// ----------------------------------------------------------------------------
// bpao_regs
// APB register file holding the observer coefficients.
// ----------------------------------------------------------------------------
module bpao_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [bpao_pkg::AddrW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output bpao_pkg::cfg_t cfg
);
	import bpao_pkg::*;

	logic [2:0] idx;
	cfg_t cfg_q;

	assign idx = paddr[4:2];
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.resistance <= 16'd819;
			cfg_q.inductance <= '0;
			cfg_q.pll_kp <= '0;
			cfg_q.pll_ki <= '0;
			cfg_q.sample_period <= '0;
			cfg_q.inv_sample_period <= 16'd1;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			unique case (idx)
				REG_RES: cfg_q.resistance <= pwdata[15:0];
				REG_IND: cfg_q.inductance <= pwdata[15:0];
				REG_KP:  cfg_q.pll_kp <= pwdata[15:0];
				REG_KI:  cfg_q.pll_ki <= pwdata[15:0];
				REG_DT:  cfg_q.sample_period <= pwdata[15:0];
				REG_INV: cfg_q.inv_sample_period <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			unique case (idx)
				REG_RES: prdata = {16'd0, cfg_q.resistance};
				REG_IND: prdata = {16'd0, cfg_q.inductance};
				REG_KP:  prdata = {16'd0, cfg_q.pll_kp};
				REG_KI:  prdata = {16'd0, cfg_q.pll_ki};
				REG_DT:  prdata = {16'd0, cfg_q.sample_period};
				REG_INV: prdata = {16'd0, cfg_q.inv_sample_period};
				default: prdata = '0;
			endcase
		end
	end
endmodule

// ===== sv/bpao_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpao_ctrl
// Sequencer: steps the datapath through one sample and runs the handshakes.
// ----------------------------------------------------------------------------
module bpao_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output bpao_pkg::cmd_t cmd
);
	import bpao_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_RUN, S_OUT} state_t;

	state_t state_q;
	op_t op_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd.op = OP_NONE;
		if (state_q == S_IDLE && in_valid) cmd.op = OP_LOAD;
		else if (state_q == S_RUN) cmd.op = op_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_NONE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_RUN;
					op_q <= OP_CLARKE;
				end
				S_RUN: begin
					if (op_q == OP_DONE) state_q <= S_OUT;
					else op_q <= op_t'(op_q + 5'd1);
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/bpao_dp.sv =====
// ----------------------------------------------------------------------------
// bpao_dp
// Datapath: one shared multiplier, an accumulator and the observer state.
// ----------------------------------------------------------------------------
module bpao_dp (
	input  logic clk,
	input  logic arst_n,
	input  bpao_pkg::cmd_t cmd,
	input  bpao_pkg::cfg_t cfg,
	input  logic signed [15:0] phase_a_current,
	input  logic signed [15:0] phase_b_current,
	input  logic signed [15:0] v_alpha,
	input  logic signed [15:0] v_beta,
	output logic [15:0] angle,
	output logic signed [31:0] speed,
	output logic signed [15:0] i_d,
	output logic signed [15:0] i_q,
	output logic signed [15:0] emf_alpha,
	output logic signed [15:0] emf_beta
);
	import bpao_pkg::*;

	logic signed [15:0] ia_q, ib_q, va_q, vb_q, ibe_q, pa_q, pb_q, ea_q, eb_q;
	logic signed [15:0] id_q, iq_q;
	logic signed [31:0] integ_q, speed_q;
	logic signed [17:0] eq_q;
	logic [15:0] ang_q;
	logic signed [63:0] acc_q, tmp_q;
	logic signed [33:0] ma;
	logic signed [33:0] mb;
	logic signed [67:0] prod;
	logic signed [16:0] s_old, c_old, s_new, c_new;

	assign s_old = sine_lut(ang_q);
	assign c_old = sine_lut(ang_q + 16'd16384);
	assign s_new = s_old;
	assign c_new = c_old;
	assign prod = ma * mb;

	function automatic logic signed [63:0] rsh(input logic signed [63:0] v, input int s);
		logic signed [63:0] x;
		x = v + (64'sd1 <<< (s - 1));
		return x >>> s;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) return 16'sh7fff;
		if (v < -64'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_CLARKE: begin
				ma = 34'(ia_q) + 34'(ib_q) + 34'(ib_q);
				mb = 34'sd37837;
			end
			OP_EA_R:  begin ma = 34'(ia_q); mb = 34'($signed({1'b0, cfg.resistance})); end
			OP_EA_L1: begin ma = 34'(ia_q) - 34'(pa_q); mb = 34'($signed({1'b0, cfg.inductance})); end
			OP_EA_L2, OP_EB_L2: begin
				ma = 34'(tmp_q); mb = 34'($signed({1'b0, cfg.inv_sample_period}));
			end
			OP_EB_R:  begin ma = 34'(ibe_q); mb = 34'($signed({1'b0, cfg.resistance})); end
			OP_EB_L1: begin ma = 34'(ibe_q) - 34'(pb_q); mb = 34'($signed({1'b0, cfg.inductance})); end
			OP_EQ_C:  begin ma = 34'(eb_q); mb = 34'(c_old); end
			OP_EQ_S:  begin ma = 34'(ea_q); mb = 34'(s_old); end
			OP_KI1:   begin ma = 34'(eq_q); mb = 34'($signed({1'b0, cfg.pll_ki})); end
			OP_KI2: begin
				ma = 34'(tmp_q); mb = 34'($signed({1'b0, cfg.sample_period}));
			end
			OP_KP:    begin ma = 34'(eq_q); mb = 34'($signed({1'b0, cfg.pll_kp})); end
			OP_STEP1: begin ma = 34'(speed_q); mb = 34'sd10430; end
			// split the 46-bit speed product into low and high halves
			OP_STEP2: begin
				ma = 34'({1'b0, tmp_q[22:0]}); mb = 34'($signed({1'b0, cfg.sample_period}));
			end
			OP_STEP3: begin
				ma = 34'($signed(tmp_q[45:23])); mb = 34'($signed({1'b0, cfg.sample_period}));
			end
			OP_ID_C:  begin ma = 34'(ia_q); mb = 34'(c_new); end
			OP_ID_S:  begin ma = 34'(ibe_q); mb = 34'(s_new); end
			OP_IQ_C:  begin ma = 34'(ibe_q); mb = 34'(c_new); end
			OP_IQ_S:  begin ma = 34'(ia_q); mb = 34'(s_new); end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pa_q <= '0;
			pb_q <= '0;
			integ_q <= '0;
			ang_q <= '0;
		end else begin
			case (cmd.op)
				OP_CLARKE: pa_q <= pa_q;
				OP_EA_FIN: pa_q <= ia_q;
				OP_EB_FIN: pb_q <= ibe_q;
				OP_KP: integ_q <= sat32(64'(integ_q) + rsh(acc_q, 23));
				OP_ANG: ang_q <= ang_q + 16'(rsh(acc_q, 32));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				ia_q <= phase_a_current;
				ib_q <= phase_b_current;
				va_q <= v_alpha;
				vb_q <= v_beta;
			end
			OP_CLARKE: ibe_q <= sat16(rsh(64'(prod), 16));
			OP_EA_R, OP_EB_R: acc_q <= -64'(prod);
			OP_EA_L1, OP_EB_L1, OP_KI1, OP_STEP1: tmp_q <= 64'(prod);
			OP_EA_L2, OP_EB_L2: acc_q <= acc_q - 64'(prod);
			OP_EA_FIN: ea_q <= sat16(rsh(acc_q + (64'(va_q) <<< 12), 12));
			OP_EB_FIN: eb_q <= sat16(rsh(acc_q + (64'(vb_q) <<< 12), 12));
			OP_EQ_C, OP_ID_C, OP_IQ_C: acc_q <= 64'(prod);
			OP_EQ_S, OP_IQ_S: acc_q <= acc_q - 64'(prod);
			OP_EQ_FIN: eq_q <= 18'(rsh(acc_q, 15));
			OP_KI2: acc_q <= 64'(prod);
			OP_KP: speed_q <= sat32(rsh(64'(prod), 7) +
				64'(sat32(64'(integ_q) + rsh(acc_q, 23))));
			OP_STEP2: acc_q <= 64'(prod);
			OP_STEP3: acc_q <= acc_q + (64'(prod) <<< 23);
			OP_ID_S: begin
				acc_q <= acc_q + 64'(prod);
			end
			default: ;
		endcase
		if (cmd.op == OP_IQ_C) id_q <= sat16(rsh(acc_q, 15));
		if (cmd.op == OP_DONE) iq_q <= sat16(rsh(acc_q, 15));
	end

	assign angle = ang_q;
	assign speed = speed_q;
	assign i_d = id_q;
	assign i_q = iq_q;
	assign emf_alpha = ea_q;
	assign emf_beta = eb_q;
endmodule

// ===== sv/backemf_pll_angle_observer.sv =====
// ----------------------------------------------------------------------------
// backemf_pll_angle_observer
// Sensorless back-EMF observer with PLL angle and speed tracking.
// ----------------------------------------------------------------------------
// Every product of a sample is handled in turn by the single shared multiplier;
// the next sample can be taken in the cycle after the result transfer, so a new
// sample is not accepted until the last result is taken. Registers are written
// over APB.
module backemf_pll_angle_observer (
	input  logic clk,
	input  logic arst_n,
	bpao_in_if.sink in_ch,
	bpao_out_if.source out_ch,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [bpao_pkg::AddrW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import bpao_pkg::*;

	cfg_t cfg;
	cmd_t cmd;

	bpao_regs u_regs (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg);

	bpao_ctrl u_ctrl (.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .cmd);

	bpao_dp u_dp (.clk, .arst_n, .cmd, .cfg,
		.phase_a_current(in_ch.phase_a_current), .phase_b_current(in_ch.phase_b_current),
		.v_alpha(in_ch.v_alpha), .v_beta(in_ch.v_beta),
		.angle(out_ch.angle), .speed(out_ch.speed), .i_d(out_ch.i_d), .i_q(out_ch.i_q),
		.emf_alpha(out_ch.emf_alpha), .emf_beta(out_ch.emf_beta));
endmodule

// ===== sv/bpao_checker.sv =====
// ----------------------------------------------------------------------------
// bpao_checker
// Port-level checks of the observer.
// ----------------------------------------------------------------------------
module bpao_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic pready
);
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("result too early");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready)
		else $error("not idle after transfer");
	assert property (@(posedge clk) pready)
		else $error("pready low");
endmodule

bind backemf_pll_angle_observer bpao_checker u_chk (.clk, .arst_n,
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .pready);
